[rtl/nrv2b_pkg.sv]
// Package: shared types and constants for the NRV2B decompressor.
`timescale 1ns / 1ps
package nrv2b_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 65536;
  localparam logic [31:0] GAMMA_LIMIT = 32'h0100_0002;
  localparam logic [31:0] END_MARK    = 32'hffff_ffff;
  localparam logic [31:0] FAR_OFFSET  = 32'h0000_0d00;

  localparam logic CFG_SOURCE_LENGTH   = 1'b0;
  localparam logic CFG_OUTPUT_CAPACITY = 1'b1;

  localparam logic ACT_PUSH    = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  localparam logic [2:0] ST_RUN      = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_IN_OVR   = 3'd2;
  localparam logic [2:0] ST_OUT_OVR  = 3'd3;
  localparam logic [2:0] ST_LB_OVR   = 3'd4;
  localparam logic [2:0] ST_LEFTOVER = 3'd5;

  typedef enum logic [10:0] {
    PH_LIT_FLAG = 11'b000_0000_0001,
    PH_LIT_BYTE = 11'b000_0000_0010,
    PH_OFF_BIT  = 11'b000_0000_0100,
    PH_OFF_END  = 11'b000_0000_1000,
    PH_OFF_BYTE = 11'b000_0001_0000,
    PH_LEN_A    = 11'b000_0010_0000,
    PH_LEN_B    = 11'b000_0100_0000,
    PH_LEN_BIT  = 11'b000_1000_0000,
    PH_LEN_END  = 11'b001_0000_0000,
    PH_COPY     = 11'b010_0000_0000,
    PH_DONE     = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        wants_byte;
    logic [2:0]  status;
    logic        finished;
    logic [31:0] out_count;
  } out_item_t;

endpackage

[rtl/nrv2b_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module nrv2b_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/nrv2b_fifo.sv]
// Short queue of input items between the front and the decode engine.
`timescale 1ns / 1ps
module nrv2b_fifo
  import nrv2b_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  in_item_t wr_data,
  output logic     full,
  input  logic     rd_en,
  output in_item_t rd_data,
  output logic     empty
);
  in_item_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule

[rtl/nrv2b_engine.sv]
// Decode engine: one decode step per queued item, result into an output register.
`timescale 1ns / 1ps
module nrv2b_engine
  import nrv2b_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] source_length,
  input  logic [31:0] output_capacity,
  input  in_item_t    item,
  input  logic        item_avail,
  output logic        item_take,
  output out_item_t   res,
  output logic        res_valid,
  input  logic        res_take
);
  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam logic [32:0] WIN33 = 33'(WINDOW_DEPTH);

  phase_t      ph_r, ph_nxt;
  logic [31:0] buf_r, buf_nxt;
  logic [4:0]  left_r, left_nxt;
  logic [1:0]  wseen_r, wseen_nxt;
  logic        loaded_r, loaded_nxt;
  logic [31:0] cons_r, cons_nxt, prod_r, prod_nxt, prev_r, prev_nxt;
  logic [31:0] off_r, off_nxt, len_r, len_nxt;
  logic [2:0]  fst_r, fst_nxt;
  logic        rd_pend_r;   // copy step waiting on history read data
  logic        fin, valid;
  logic [7:0]  obyte;
  logic        hwe;
  logic [AW-1:0] raddr;
  logic [7:0]  rdata;
  logic        flag_ph, need_word, wovr, bit_v;
  logic [32:0] v33, clen;
  logic        step;

  nrv2b_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_hist (
    .clk(clk), .we(hwe), .waddr(prod_r[AW-1:0]), .wdata(obyte),
    .raddr(raddr), .rdata(rdata)
  );

  assign raddr = AW'(prod_r - off_r);
  assign flag_ph = (ph_r == PH_LIT_FLAG) || (ph_r == PH_OFF_BIT) || (ph_r == PH_OFF_END) ||
                   (ph_r == PH_LEN_A) || (ph_r == PH_LEN_B) || (ph_r == PH_LEN_BIT) ||
                   (ph_r == PH_LEN_END);
  assign need_word = flag_ph && (left_r == 5'd0) && !loaded_r;
  assign wovr = (wseen_r == 2'd0) && ({1'b0, cons_r} + 33'd4 > {1'b0, source_length});
  // copy advance waits for the registered history read
  assign step = item_avail && (!res_valid || res_take) &&
                !(item.action == ACT_ADVANCE && ph_r == PH_COPY && !rd_pend_r);
  assign item_take = step;

  always_comb begin
    ph_nxt = ph_r; buf_nxt = buf_r; left_nxt = left_r; wseen_nxt = wseen_r;
    loaded_nxt = loaded_r; cons_nxt = cons_r; prod_nxt = prod_r; prev_nxt = prev_r;
    off_nxt = off_r; len_nxt = len_r; fst_nxt = fst_r;
    fin = 1'b0; valid = 1'b0; obyte = 8'd0; hwe = 1'b0; bit_v = 1'b0;
    v33 = 33'd0; clen = 33'd0;
    if (ph_r == PH_DONE) begin
    end else if (item.action == ACT_PUSH) begin
      if (need_word) begin
        if (wovr) begin
          fst_nxt = ST_IN_OVR; ph_nxt = PH_DONE; fin = 1'b1;
        end else begin
          unique case (wseen_r)
            2'd0: buf_nxt = {24'd0, item.in_byte};
            2'd1: buf_nxt[15:8] = item.in_byte;
            2'd2: buf_nxt[23:16] = item.in_byte;
            default: buf_nxt[31:24] = item.in_byte;
          endcase
          cons_nxt = cons_r + 32'd1;
          wseen_nxt = wseen_r + 2'd1;
          if (wseen_r == 2'd3) loaded_nxt = 1'b1;
        end
      end else if (ph_r == PH_LIT_BYTE) begin
        cons_nxt = cons_r + 32'd1;
        obyte = item.in_byte; valid = 1'b1; hwe = 1'b1;
        prod_nxt = prod_r + 32'd1;
        ph_nxt = PH_LIT_FLAG;
      end else if (ph_r == PH_OFF_BYTE) begin
        cons_nxt = cons_r + 32'd1;
        off_nxt = {off_r[23:0] - 24'd3, item.in_byte};
        if (off_nxt == END_MARK) begin
          ph_nxt = PH_DONE; fin = 1'b1;
          if (cons_nxt == source_length) fst_nxt = ST_OK;
          else if (cons_nxt < source_length) fst_nxt = ST_LEFTOVER;
          else fst_nxt = ST_IN_OVR;
        end else begin
          off_nxt = off_nxt + 32'd1;
          prev_nxt = off_nxt;
          ph_nxt = PH_LEN_A;
        end
      end
    end else if (ph_r == PH_COPY) begin
      obyte = rdata; valid = 1'b1; hwe = 1'b1;
      prod_nxt = prod_r + 32'd1;
      if (len_r == 32'd0) ph_nxt = PH_LIT_FLAG;
      else len_nxt = len_r - 32'd1;
    end else if (flag_ph) begin
      if (need_word) begin
        if (wovr) begin
          fst_nxt = ST_IN_OVR; ph_nxt = PH_DONE; fin = 1'b1;
        end
      end else begin
        if (loaded_r) begin
          loaded_nxt = 1'b0; left_nxt = 5'd31; bit_v = buf_r[31];
        end else begin
          left_nxt = left_r - 5'd1; bit_v = buf_r[left_nxt];
        end
        unique case (ph_r)
          PH_LIT_FLAG: begin
            if (bit_v) begin
              if (cons_r >= source_length) begin
                fst_nxt = ST_IN_OVR; ph_nxt = PH_DONE; fin = 1'b1;
              end else if (prod_r >= output_capacity) begin
                fst_nxt = ST_OUT_OVR; ph_nxt = PH_DONE; fin = 1'b1;
              end else ph_nxt = PH_LIT_BYTE;
            end else begin
              off_nxt = 32'd1; ph_nxt = PH_OFF_BIT;
            end
          end
          PH_OFF_BIT: begin
            off_nxt = {off_r[30:0], bit_v};
            if (off_nxt > GAMMA_LIMIT) begin
              fst_nxt = ST_LB_OVR; ph_nxt = PH_DONE; fin = 1'b1;
            end else ph_nxt = PH_OFF_END;
          end
          PH_OFF_END: begin
            if (!bit_v) ph_nxt = PH_OFF_BIT;
            else if (off_r == 32'd2) begin
              off_nxt = prev_r; ph_nxt = PH_LEN_A;
            end else if (cons_r >= source_length) begin
              fst_nxt = ST_IN_OVR; ph_nxt = PH_DONE; fin = 1'b1;
            end else ph_nxt = PH_OFF_BYTE;
          end
          PH_LEN_A: begin
            len_nxt = {31'd0, bit_v}; ph_nxt = PH_LEN_B;
          end
          PH_LEN_B: begin
            len_nxt = {len_r[30:0], bit_v};
            if (len_nxt == 32'd0) begin
              len_nxt = 32'd1; ph_nxt = PH_LEN_BIT;
            end else clen = {1'b0, len_nxt};
          end
          PH_LEN_BIT: begin
            v33 = {len_r, bit_v};
            if (v33 >= {1'b0, output_capacity}) begin
              fst_nxt = ST_OUT_OVR; ph_nxt = PH_DONE; fin = 1'b1;
            end else begin
              len_nxt = v33[31:0]; ph_nxt = PH_LEN_END;
            end
          end
          default: begin
            if (!bit_v) ph_nxt = PH_LEN_BIT;
            else begin
              v33 = {1'b0, len_r} + 33'd2;
              if (v33[32]) begin
                fst_nxt = ST_OUT_OVR; ph_nxt = PH_DONE; fin = 1'b1;
              end else clen = v33;
            end
          end
        endcase
        // match start: capacity then lookbehind checks
        if (clen != 33'd0) begin
          clen = clen + 33'(off_nxt > FAR_OFFSET);
          if ({1'b0, prod_r} + clen > {1'b0, output_capacity}) begin
            fst_nxt = ST_OUT_OVR; ph_nxt = PH_DONE; fin = 1'b1;
          end else if (off_nxt > prod_r || {1'b0, off_nxt} > WIN33) begin
            fst_nxt = ST_LB_OVR; ph_nxt = PH_DONE; fin = 1'b1;
          end else begin
            len_nxt = clen[31:0]; ph_nxt = PH_COPY;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_LIT_FLAG; buf_r <= '0; left_r <= '0; wseen_r <= '0; loaded_r <= 1'b0;
      cons_r <= '0; prod_r <= '0; prev_r <= 32'd1; off_r <= '0; len_r <= '0;
      fst_r <= ST_RUN; res_valid <= 1'b0; rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= item_avail && item.action == ACT_ADVANCE && ph_r == PH_COPY &&
                   !rd_pend_r && !step;
      if (step) begin
        ph_r <= ph_nxt; buf_r <= buf_nxt; left_r <= left_nxt; wseen_r <= wseen_nxt;
        loaded_r <= loaded_nxt; cons_r <= cons_nxt; prod_r <= prod_nxt; prev_r <= prev_nxt;
        off_r <= off_nxt; len_r <= len_nxt; fst_r <= fst_nxt;
      end
      if (step) res_valid <= 1'b1;
      else if (res_take) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.out_byte   <= obyte;
      res.out_valid  <= valid;
      res.wants_byte <= (ph_nxt == PH_LIT_BYTE) || (ph_nxt == PH_OFF_BYTE) ||
                        (((ph_nxt == PH_LIT_FLAG) || (ph_nxt == PH_OFF_BIT) ||
                          (ph_nxt == PH_OFF_END) || (ph_nxt == PH_LEN_A) ||
                          (ph_nxt == PH_LEN_B) || (ph_nxt == PH_LEN_BIT) ||
                          (ph_nxt == PH_LEN_END)) && left_nxt == 5'd0 && !loaded_nxt);
      res.status     <= fst_nxt;
      res.finished   <= fin;
      res.out_count  <= prod_nxt;
    end
  end
endmodule

[rtl/nrv2b_le32_decompressor.sv]
// Top level: NRV2B little-endian 32-bit flag word decompressor.
//
// Input queue: each transfer (push high, full low) carries an action and a
// byte: action push delivers one compressed byte, action advance asks for one
// decode step. Every input item yields exactly one result item on the output
// queue (empty low shows it, pop takes it), in order.
// Configuration: cfg_index 0 writes source_length, 1 writes output_capacity;
// cfg_ready is always high, writes take effect at once.
// The engine takes the queue head straight into its result register, so a result
// passes through the input queue and then that register. Throughput: one item per
// cycle while the output queue is not stalled, except an advance in a match copy,
// which waits for the registered history read.
// A stalled output queue stalls the engine; the two-entry input queue keeps
// accepting until it fills.
// Reset (rst_n low at a clock edge) clears all decode state; the history
// memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module nrv2b_le32_decompressor
  import nrv2b_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  logic [31:0] src_len_r, cap_r;
  in_item_t    q_item;
  logic        q_empty, q_take, res_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_len_r <= '0;
      cap_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SOURCE_LENGTH:   src_len_r <= cfg_data;
        CFG_OUTPUT_CAPACITY: cap_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  nrv2b_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(push && !full), .wr_data(in_item), .full(full),
    .rd_en(q_take), .rd_data(q_item), .empty(q_empty)
  );

  nrv2b_engine #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_engine (
    .clk(clk), .rst_n(rst_n), .source_length(src_len_r), .output_capacity(cap_r),
    .item(q_item), .item_avail(!q_empty), .item_take(q_take),
    .res(out_item), .res_valid(res_valid), .res_take(pop && !empty)
  );

  assign empty = !res_valid;
endmodule

[rtl/nrv2b_checker.sv]
// Port-level checker for the decompressor, bound to the top level.
`timescale 1ns / 1ps
module nrv2b_checker
  import nrv2b_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.status <= ST_LEFTOVER)) else $error("status code out of range");
  a_fin_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.finished) |-> (out_item.status != ST_RUN))
    else $error("finish without final status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item))) else $error("result changed while stalled");
  a_reset_empty: assert property (@(posedge clk) !$past(rst_n) |-> (empty && !full))
    else $error("queue not idle after reset");
endmodule

bind nrv2b_le32_decompressor nrv2b_checker u_checker (
  .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop),
  .out_item(out_item)
);
